[rtl/crr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types, constants and saturating fixed-point helpers for the
// cardiac reaction rate pipeline.
// ----------------------------------------------------------------------------
package crr_pkg;

    typedef logic signed [31:0] t_word;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    // configuration register index
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K   = 4'd0,
        CFG_A   = 4'd1,
        CFG_B   = 4'd2,
        CFG_IC  = 4'd3,
        CFG_EPS = 4'd4,
        CFG_MU1 = 4'd5,
        CFG_MU2 = 4'd6,
        CFG_KA  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        t_word k;
        t_word a;
        t_word b;
        t_word ic;
        t_word eps;
        t_word mu1;
        t_word mu2;
        t_word ka;
    } t_cfg;

    // divider: quotient bits resolved, plus entry and exit registers
    localparam int DIV_QBITS = 32;
    localparam int DIV_LAT   = DIV_QBITS + 2;

    // stress unit latency (lookup, interpolation, two products)
    localparam int STRESS_LAT = 6;

    localparam longint S28 = 64'sd1 << 28;

    // saturate a wide signed value to 32 bits
    function automatic t_word crr_sat(input logic signed [63:0] x);
        t_word r;
        if (x > 64'sd2147483647) begin
            r = WORD_MAX;
        end else if (x < -64'sd2147483648) begin
            r = WORD_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic t_word crr_add(input t_word a, input t_word b);
        logic signed [63:0] x;
        x = a;
        x = x + b;
        return crr_sat(x);
    endfunction

    function automatic t_word crr_sub(input t_word a, input t_word b);
        logic signed [63:0] x;
        x = a;
        x = x - b;
        return crr_sat(x);
    endfunction

    function automatic t_word crr_neg(input t_word a);
        logic signed [63:0] x;
        x = a;
        x = -x;
        return crr_sat(x);
    endfunction

    // floor(a*b / 2^frac), saturated
    function automatic t_word crr_qmul(input t_word a, input t_word b, input int frac);
        logic signed [63:0] p;
        p = a * b;
        return crr_sat(p >>> frac);
    endfunction

    // unsigned n / d by shift and subtract, nonnegative operands (elaboration only)
    function automatic longint crr_udiv(input longint n, input longint d);
        logic [63:0] nu;
        logic [63:0] du;
        logic [63:0] q;
        logic [63:0] r;
        nu = n;
        du = d;
        q  = '0;
        r  = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], nu[i]};
            if (r >= du) begin
                r    = r - du;
                q[i] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // exp(-f) for 0 <= f <= 1, Q28 (elaboration only)
    function automatic longint crr_exp_series(input longint f);
        longint sum;
        longint term;
        sum  = S28;
        term = S28;
        for (int i = 1; i <= 24; i++) begin
            term = crr_udiv((term * f) >> 28, longint'(i));
            if ((i % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // exp(-x) for x >= 0, Q28 (elaboration only)
    function automatic longint crr_exp_neg(input longint x);
        longint n;
        longint r;
        longint e1;
        n  = x >> 28;
        r  = crr_exp_series(x & (S28 - 1));
        e1 = crr_exp_series(S28);
        if (n > 64) begin
            r = 0;
        end else begin
            for (int i = 0; i < 64; i++) begin
                if (i < n && r != 0) begin
                    r = (r * e1) >> 28;
                end
            end
        end
        return r;
    endfunction

    // Gompertz factor at t (Q28), rounded to frac bits (elaboration only)
    function automatic longint crr_gomp_point(input longint t, input int frac);
        longint inner;
        longint den;
        longint outer;
        longint g;
        if (t >= 0) begin
            inner = crr_exp_neg(t);
        end else begin
            den   = crr_exp_neg(-t);
            inner = (den == 0) ? (64'sd1 << 40) : crr_udiv(S28 * S28, den);
        end
        outer = crr_exp_neg(inner);
        g     = crr_udiv(S28 + 9 * outer, 64'sd10);
        return (g + (64'sd1 << (27 - frac))) >> (28 - frac);
    endfunction

endpackage

[rtl/crr_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_cfg
// Model constant register file with write channel; always ready.
// ----------------------------------------------------------------------------
module crr_cfg
    import crr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [31:0]          i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k   <= 32'sd524288;
            r_cfg.a   <= 32'sd9830;
            r_cfg.b   <= 32'sd9830;
            r_cfg.ic  <= 32'sd65536;
            r_cfg.eps <= 32'sd131;
            r_cfg.mu1 <= 32'sd13107;
            r_cfg.mu2 <= 32'sd19661;
            r_cfg.ka  <= 32'sd0;
        end else if (i_valid) begin
            unique case (t_cfg_idx'(i_index))
                CFG_K:   r_cfg.k   <= i_data;
                CFG_A:   r_cfg.a   <= i_data;
                CFG_B:   r_cfg.b   <= i_data;
                CFG_IC:  r_cfg.ic  <= i_data;
                CFG_EPS: r_cfg.eps <= i_data;
                CFG_MU1: r_cfg.mu1 <= i_data;
                CFG_MU2: r_cfg.mu2 <= i_data;
                CFG_KA:  r_cfg.ka  <= i_data;
                default: ;
            endcase
        end
    end

endmodule

[rtl/crr_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_delay
// Fixed-depth shift register used to align side data with the divider path.
// ----------------------------------------------------------------------------
module crr_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [DEPTH];

    assign o_q = r_q[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_q[i] <= '0;
            end
        end else begin
            r_q[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_q[i] <= r_q[i-1];
            end
        end
    end

endmodule

[rtl/crr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_div
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated. One quotient bit per stage.
// ----------------------------------------------------------------------------
module crr_div
    import crr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  t_word i_num,
    input  t_word i_den,
    output t_word o_quot
);

    localparam int NW = 33 + FRAC_BITS;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quot;
        logic [31:0] dn;
        logic        neg;
        logic        ovf;
        logic        nz;
    } t_dstage;

    t_dstage       r_s [DIV_QBITS+1];
    t_dstage       n_pre;
    t_dstage       n_s [DIV_QBITS];
    t_word         r_quot;
    logic [32:0]   an;
    logic [32:0]   dn33;
    logic [NW-1:0] nsh;

    // magnitudes, overflow check and first partial remainder
    always_comb begin
        an   = i_num[31] ? (33'd0 - {i_num[31], i_num}) : {1'b0, i_num};
        dn33 = i_den[31] ? (33'd0 - {i_den[31], i_den}) : {1'b0, i_den};
        nsh  = NW'(an) << FRAC_BITS;
        n_pre.rem  = 32'(nsh >> 32);
        n_pre.low  = nsh[31:0];
        n_pre.quot = '0;
        n_pre.dn   = dn33[31:0];
        n_pre.neg  = i_num[31] ^ i_den[31];
        n_pre.ovf  = 65'(nsh) >= {dn33[31:0], 33'd0} >> 1;
        n_pre.nz   = (i_num != '0);
    end

    // one trial subtraction per stage
    always_comb begin
        logic [32:0] tr;
        logic        bit_q;
        for (int i = 0; i < DIV_QBITS; i++) begin
            tr    = {r_s[i].rem, r_s[i].low[31]};
            bit_q = (tr >= {1'b0, r_s[i].dn});
            n_s[i]      = r_s[i];
            n_s[i].rem  = bit_q ? 32'(tr - {1'b0, r_s[i].dn}) : tr[31:0];
            n_s[i].low  = {r_s[i].low[30:0], 1'b0};
            n_s[i].quot = {r_s[i].quot[30:0], bit_q};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s[0] <= n_pre;
        for (int i = 0; i < DIV_QBITS; i++) begin
            r_s[i+1] <= n_s[i];
        end
    end

    // sign and saturation
    always_ff @(posedge i_clk) begin
        if (!r_s[DIV_QBITS].nz) begin
            r_quot <= '0;
        end else if (r_s[DIV_QBITS].ovf) begin
            r_quot <= r_s[DIV_QBITS].neg ? WORD_MIN : WORD_MAX;
        end else if (r_s[DIV_QBITS].neg) begin
            r_quot <= (r_s[DIV_QBITS].quot > 32'h8000_0000) ? WORD_MIN
                                                            : 32'(32'd0 - r_s[DIV_QBITS].quot);
        end else begin
            r_quot <= r_s[DIV_QBITS].quot[31] ? WORD_MAX : r_s[DIV_QBITS].quot;
        end
    end

    assign o_quot = r_quot;

endmodule

[rtl/crr_stress.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crr_stress
// Gompertz factor by table lookup with linear interpolation, and the active
// stress production rate G * ka * 100v. Six register stages.
// ----------------------------------------------------------------------------
module crr_stress
    import crr_pkg::*;
#(
    parameter int FRAC_BITS        = 16,
    parameter int GOMPERTZ_ENTRIES = 256
) (
    input  logic  i_clk,
    input  t_word i_voltage,
    input  t_word i_ka,
    output t_word o_prod,
    output t_word o_gomp
);

    localparam int XW = FRAC_BITS + 4;
    localparam int AW = $clog2(GOMPERTZ_ENTRIES + 1);
    localparam int SW = XW + AW;
    localparam int RW = FRAC_BITS + 2;
    localparam int PW = RW + XW + 3;
    localparam logic signed [39:0] X_OFF = 40'sd76 <<< FRAC_BITS;
    localparam logic signed [39:0] SPAN  = 40'sd1 <<< XW;

    logic [RW-1:0] rom [GOMPERTZ_ENTRIES+1];

    // constant table over t = 100v - 80 in [-4, 12]
    for (genvar gi = 0; gi <= GOMPERTZ_ENTRIES; gi++) begin : g_rom
        localparam longint T  = -4 * S28 + (16 * S28 * gi) / GOMPERTZ_ENTRIES;
        localparam longint PT = crr_gomp_point(T, FRAC_BITS);
        assign rom[gi] = RW'(PT);
    end

    logic signed [39:0] v100;
    logic signed [39:0] x;
    logic [SW-1:0]      scaled;
    logic [AW-1:0]      n_idx;
    logic [XW:0]        n_rem;

    logic [AW-1:0]      r1_idx;
    logic [XW:0]        r1_rem;
    t_word              r1_v100;
    logic [RW-1:0]      r2_lo;
    logic [RW-1:0]      r2_hi;
    logic [XW:0]        r2_rem;
    t_word              r2_v100;
    logic [RW-1:0]      r3_lo;
    logic signed [RW:0] r3_step;
    t_word              r3_v100;
    t_word              r4_g;
    t_word              r4_v100;
    t_word              r5_p;
    t_word              r5_g;
    t_word              r5_v100;
    t_word              r6_prod;
    t_word              r6_g;

    logic signed [RW:0]   diff;
    logic signed [XW+1:0] rems;
    logic signed [PW-1:0] prod;
    logic signed [RW+1:0] gsum;

    // table position, clamped at both ends
    always_comb begin
        v100   = $signed({{8{i_voltage[31]}}, i_voltage}) * 40'sd100;
        x      = v100 - X_OFF;
        scaled = SW'(x[XW-1:0]) * SW'(GOMPERTZ_ENTRIES);
        if (x < 0) begin
            n_idx = '0;
            n_rem = '0;
        end else if (x >= SPAN) begin
            n_idx = AW'(GOMPERTZ_ENTRIES - 1);
            n_rem = (XW+1)'(1) << XW;
        end else begin
            n_idx = scaled[SW-1:XW];
            n_rem = {1'b0, scaled[XW-1:0]};
        end
    end

    // interpolation step and sum
    always_comb begin
        diff = $signed({1'b0, r2_hi}) - $signed({1'b0, r2_lo});
        rems = $signed({1'b0, r2_rem});
        prod = diff * rems;
        gsum = $signed({2'b0, r3_lo}) + (RW+2)'(r3_step);
    end

    always_ff @(posedge i_clk) begin
        r1_idx  <= n_idx;
        r1_rem  <= n_rem;
        r1_v100 <= crr_sat(64'(v100));

        r2_lo   <= rom[r1_idx];
        r2_hi   <= rom[AW'(r1_idx + 1'b1)];
        r2_rem  <= r1_rem;
        r2_v100 <= r1_v100;

        r3_lo   <= r2_lo;
        r3_step <= (RW+1)'(prod >>> XW);
        r3_v100 <= r2_v100;

        r4_g    <= 32'(gsum);
        r4_v100 <= r3_v100;

        r5_p    <= crr_qmul(r4_g, i_ka, FRAC_BITS);
        r5_g    <= r4_g;
        r5_v100 <= r4_v100;

        r6_prod <= crr_qmul(r5_p, r5_v100, FRAC_BITS);
        r6_g    <= r5_g;
    end

    assign o_prod = r6_prod;
    assign o_gomp = r6_g;

endmodule

[rtl/cardiac_reaction_rates.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cardiac_reaction_rates
// Aliev-Panfilov reaction rates per cell: ionic current, gate variable and
// active stress production/loss, saturated fixed point.
//
//   channel   handshake                     payload
//   input     start & !busy                 i_voltage, i_gate_variable
//   config    i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//   result    o_result_valid (one cycle)    o_current_production .. o_stress_loss
//
// One item per cycle; busy stays low. The 32-stage divider on the gate loss path
// plus the eps add and three products after it set the result delay. Synchronous
// active-low reset clears the valid pipeline and delay lines; cfg gets defaults.
// Results are never held; the receiver cannot stall.
// ----------------------------------------------------------------------------
module cardiac_reaction_rates
    import crr_pkg::*;
#(
    parameter int FRAC_BITS        = 16,
    parameter int GOMPERTZ_ENTRIES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_word                i_voltage,
    input  t_word                i_gate_variable,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_result_valid,
    output t_word                o_current_production,
    output t_word                o_current_loss,
    output t_word                o_gate_production,
    output t_word                o_gate_loss,
    output t_word                o_stress_production,
    output t_word                o_stress_loss
);

    localparam t_word ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam int    LAT   = DIV_LAT + 5;

    t_cfg  cfg;
    logic  accept;

    t_word r1_v, r1_w, r1_pvv, r1_pav, r1_pkv, r1_pka, r1_num, r1_den, r1_d;
    t_word r2_t, r2_s, r2_pkv;
    t_word r3_m, r3_r1;
    t_word r4_r0, r4_r1;
    t_word quot;
    t_word r_loss;
    t_word r_l1, r_l1_loss;
    t_word r_l2, r_l2_d, r_l2_loss;
    t_word r_out_r2, r_out_loss;
    t_word s_prod, s_gomp;
    t_word vd_v, vd_d, d_r0, d_r1, d_r4, d_r5;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    crr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // current and gate front end
    always_ff @(posedge i_clk) begin
        r1_v   <= i_voltage;
        r1_w   <= i_gate_variable;
        r1_pvv <= crr_qmul(i_voltage, i_voltage, FRAC_BITS);
        r1_pav <= crr_qmul(cfg.a, i_voltage, FRAC_BITS);
        r1_pkv <= crr_qmul(crr_neg(cfg.k), i_voltage, FRAC_BITS);
        r1_pka <= crr_qmul(cfg.k, cfg.a, FRAC_BITS);
        r1_num <= crr_qmul(cfg.mu1, i_gate_variable, FRAC_BITS);
        r1_den <= crr_add(cfg.mu2, i_voltage);
        r1_d   <= crr_sub(crr_sub(i_voltage, cfg.b), ONE_Q);

        r2_t   <= crr_sub(crr_sub(r1_pvv, r1_pav), r1_v);
        r2_s   <= crr_add(r1_pka, r1_w);
        r2_pkv <= r1_pkv;

        r3_m   <= crr_qmul(r2_pkv, r2_t, FRAC_BITS);
        r3_r1  <= crr_qmul(r2_s, cfg.ic, FRAC_BITS);

        r4_r0  <= crr_qmul(r3_m, cfg.ic, FRAC_BITS);
        r4_r1  <= r3_r1;
    end

    crr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_num  (r1_num),
        .i_den  (r1_den),
        .o_quot (quot)
    );

    crr_stress #(
        .FRAC_BITS        (FRAC_BITS),
        .GOMPERTZ_ENTRIES (GOMPERTZ_ENTRIES)
    ) u_stress (
        .i_clk     (i_clk),
        .i_voltage (i_voltage),
        .i_ka      (cfg.ka),
        .o_prod    (s_prod),
        .o_gomp    (s_gomp)
    );

    // align side data with the divider path
    crr_delay #(.W(64), .DEPTH(DIV_LAT + 2)) u_dly_vd (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_d   ({r1_v, r1_d}), .o_q ({vd_v, vd_d})
    );

    crr_delay #(.W(64), .DEPTH(DIV_LAT + 1)) u_dly_cur (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_d   ({r4_r0, r4_r1}), .o_q ({d_r0, d_r1})
    );

    crr_delay #(.W(64), .DEPTH(DIV_LAT + 5 - STRESS_LAT)) u_dly_str (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_d   ({s_prod, s_gomp}), .o_q ({d_r4, d_r5})
    );

    crr_delay #(.W(1), .DEPTH(LAT)) u_dly_vld (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_d   (accept), .o_q (o_result_valid)
    );

    // gate loss and production tail
    always_ff @(posedge i_clk) begin
        r_loss     <= crr_add(cfg.eps, quot);

        r_l1       <= crr_qmul(crr_neg(r_loss), cfg.k, FRAC_BITS);
        r_l1_loss  <= r_loss;

        r_l2       <= crr_qmul(r_l1, vd_v, FRAC_BITS);
        r_l2_d     <= vd_d;
        r_l2_loss  <= r_l1_loss;

        r_out_r2   <= crr_qmul(r_l2, r_l2_d, FRAC_BITS);
        r_out_loss <= r_l2_loss;
    end

    assign o_current_production = d_r0;
    assign o_current_loss       = d_r1;
    assign o_gate_production    = r_out_r2;
    assign o_gate_loss          = r_out_loss;
    assign o_stress_production  = d_r4;
    assign o_stress_loss        = d_r5;

endmodule

[bench/tb_cardiac_reaction_rates.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cardiac_reaction_rates
// Self-checking bench for the Aliev-Panfilov reaction rate block. A local
// fixed-point predictor (own Gompertz table, saturating arithmetic) computes
// the six rates of each accepted transaction. The monitor compares every
// result strobe with the oldest expected set. Configuration is rewritten
// between phases while the pipeline is empty, and the sender idles at
// different rates per phase.
// ----------------------------------------------------------------------------
module tb_cardiac_reaction_rates;
    import crr_pkg::*;

    localparam int     FRAC         = 16;
    localparam int     ROM_POINTS   = 256;
    localparam longint UNIT         = 64'sd1 << FRAC;
    localparam longint Q28          = 64'sd1 << 28;
    localparam int     DRAIN_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd11;

    typedef struct {
        t_word current_production;
        t_word current_loss;
        t_word gate_production;
        t_word gate_loss;
        t_word stress_production;
        t_word stress_loss;
    } rates_t;

    typedef struct {
        t_word voltage;
        t_word gate;
    } cell_t;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_word voltage = '0;
    t_word gate    = '0;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic  res_valid;
    t_word cur_prod, cur_loss, gate_prod, gate_loss_o, str_prod, str_loss;

    cardiac_reaction_rates u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .start               (start),
        .busy                (busy),
        .i_voltage           (voltage),
        .i_gate_variable     (gate),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_result_valid      (res_valid),
        .o_current_production(cur_prod),
        .o_current_loss      (cur_loss),
        .o_gate_production   (gate_prod),
        .o_gate_loss         (gate_loss_o),
        .o_stress_production (str_prod),
        .o_stress_loss       (str_loss)
    );

    cell_t  cell_queue[$];
    rates_t rate_queue[$];
    t_word  model_regs[2**CFG_IDX_W];
    longint gomp_rom[0:ROM_POINTS];
    int     idle_pct = 0;
    bit     failed   = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic t_word clip(input longint x);
        if (x > 64'sd2147483647) return WORD_MAX;
        if (x < -64'sd2147483648) return WORD_MIN;
        return t_word'(x);
    endfunction

    function automatic t_word fx_mul(input t_word a, input t_word b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip(p >>> FRAC);
    endfunction

    function automatic t_word fx_div(input t_word n, input t_word d);
        if (d == 0) return (n > 0) ? WORD_MAX : ((n < 0) ? WORD_MIN : t_word'(0));
        return clip((longint'(n) * UNIT) / longint'(d));
    endfunction

    // exp(-f), 0 <= f <= 1, Q28 Taylor series
    function automatic longint decay_series(input longint f);
        longint sum;
        longint term;
        sum  = Q28;
        term = Q28;
        for (int i = 1; i <= 24; i++) begin
            term = ((term * f) >> 28) / i;
            sum  = (i % 2 == 1) ? sum - term : sum + term;
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // exp(-x), x >= 0, Q28: integer part by repeated e^-1
    function automatic longint decay(input longint x);
        longint n;
        longint r;
        longint e1;
        n  = x >> 28;
        r  = decay_series(x & (Q28 - 1));
        e1 = decay_series(Q28);
        if (n > 64) return 0;
        for (longint i = 0; i < n && r != 0; i++) r = (r * e1) >> 28;
        return r;
    endfunction

    function automatic longint gomp_at(input longint t);
        longint inner;
        longint den;
        longint g;
        if (t >= 0) begin
            inner = decay(t);
        end else begin
            den   = decay(-t);
            inner = (den == 0) ? (64'sd1 << 40) : (Q28 * Q28) / den;
        end
        g = (Q28 + 9 * decay(inner)) / 10;
        return (g + (64'sd1 << (27 - FRAC))) >> (28 - FRAC);
    endfunction

    // table lookup over t = 100v-80 in [-4, 12] with floor interpolation
    function automatic t_word gomp_lookup(input t_word v);
        longint span;
        longint x;
        longint scaled;
        longint idx;
        longint rem;
        longint step;
        span = 16 * UNIT;
        x    = 100 * longint'(v) - 76 * UNIT;
        if (x < 0) return t_word'(gomp_rom[0]);
        if (x >= span) return t_word'(gomp_rom[ROM_POINTS]);
        scaled = x * ROM_POINTS;
        idx    = scaled / span;
        rem    = scaled % span;
        step   = (gomp_rom[idx + 1] - gomp_rom[idx]) * rem;
        return t_word'(gomp_rom[idx] + (step >>> 20));
    endfunction

    function automatic rates_t predict_rates(input t_word v, input t_word w);
        rates_t r;
        t_word  k, a, b, ic, eps, mu1, mu2, ka;
        t_word  poly, loss, gap, g;
        k   = model_regs[CFG_K];
        a   = model_regs[CFG_A];
        b   = model_regs[CFG_B];
        ic  = model_regs[CFG_IC];
        eps = model_regs[CFG_EPS];
        mu1 = model_regs[CFG_MU1];
        mu2 = model_regs[CFG_MU2];
        ka  = model_regs[CFG_KA];
        poly = clip(longint'(clip(longint'(fx_mul(v, v)) - fx_mul(a, v))) - v);
        r.current_production = fx_mul(fx_mul(fx_mul(clip(-longint'(k)), v), poly), ic);
        r.current_loss = fx_mul(clip(longint'(fx_mul(k, a)) + w), ic);
        loss = clip(longint'(eps) + fx_div(fx_mul(mu1, w), clip(longint'(mu2) + v)));
        r.gate_loss = loss;
        gap = clip(longint'(clip(longint'(v) - b)) - UNIT);
        r.gate_production = fx_mul(fx_mul(fx_mul(clip(-longint'(loss)), k), v), gap);
        g = gomp_lookup(v);
        r.stress_loss = g;
        r.stress_production = fx_mul(fx_mul(g, ka), clip(100 * longint'(v)));
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                rate_queue.insert(rate_queue.size(), predict_rates(voltage, gate));
                void'(cell_queue.pop_front());
            end
            if (cell_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start   <= 1'b1;
                voltage <= cell_queue[0].voltage;
                gate    <= cell_queue[0].gate;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    task automatic check_field(input string name, input t_word exp_v, input t_word act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk) begin
        rates_t e;
        if (rst_n && res_valid) begin
            if (rate_queue.size() == 0) begin
                $display("%0t unexpected result transaction", $time);
                failed = 1'b1;
            end else begin
                e = rate_queue.pop_front();
                check_field("current_production", e.current_production, cur_prod);
                check_field("current_loss", e.current_loss, cur_loss);
                check_field("gate_production", e.gate_production, gate_prod);
                check_field("gate_loss", e.gate_loss, gate_loss_o);
                check_field("stress_production", e.stress_production, str_prod);
                check_field("stress_loss", e.stress_loss, str_loss);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= CFG_KA) model_regs[idx] = val;
    endtask

    task automatic drain();
        while (cell_queue.size() > 0 || rate_queue.size() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic t_word pick_word(input int mode);
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 4 * UNIT)) - t_word'(2 * UNIT);
            2: return t_word'($urandom_range(46000, 62000));
            default: return -model_regs[CFG_MU2] + t_word'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    task automatic queue_random(input int count);
        cell_t c;
        for (int i = 0; i < count; i++) begin
            c.voltage = pick_word($urandom_range(3));
            c.gate    = pick_word($urandom_range(1));
            cell_queue.insert(cell_queue.size(), c);
        end
    endtask

    task automatic queue_cell(input t_word v, input t_word w);
        cell_t c;
        c.voltage = v;
        c.gate    = w;
        cell_queue.insert(cell_queue.size(), c);
    endtask

    initial begin
        t_word extremes[4];
        model_regs = '{0: 524288, 1: 9830, 2: 9830, 3: 65536, 4: 131, 5: 13107,
                       6: 19661, default: 0};
        for (int i = 0; i <= ROM_POINTS; i++) begin
            gomp_rom[i] = gomp_at(-4 * Q28 + (16 * Q28 * i) / ROM_POINTS);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nonzero stress gain so stress production is exercised
        write_reg(CFG_KA, 32'sd65536);
        cfg_valid <= 1'b0;
        @(posedge clk);

        // directed: field extremes, zero divisor, table edges
        extremes = '{WORD_MAX, WORD_MIN, 32'sd0, 32'sd65536};
        foreach (extremes[i]) begin
            foreach (extremes[j]) queue_cell(extremes[i], extremes[j]);
        end
        queue_cell(-32'sd19661, 32'sd65536);   // zero divisor, positive numerator
        queue_cell(-32'sd19661, -32'sd65536);  // zero divisor, negative numerator
        queue_cell(-32'sd19661, 32'sd0);       // zero divisor, zero numerator
        queue_cell(32'sd49807, 32'sd100);      // just below the table start
        queue_cell(32'sd49808, 32'sd100);      // table start
        queue_cell(32'sd60293, 32'sd100);      // near table end
        queue_cell(32'sd60294, 32'sd100);      // past table end
        idle_pct = 23;
        drain();

        // phase 1: moderate random setting
        write_reg(CFG_K, t_word'($urandom_range(0, 16 * UNIT)));
        write_reg(CFG_A, t_word'($urandom_range(0, UNIT)));
        write_reg(CFG_B, t_word'($urandom_range(0, UNIT)));
        write_reg(CFG_IC, t_word'($urandom_range(UNIT / 4, 4 * UNIT)));
        write_reg(CFG_EPS, t_word'($urandom_range(0, UNIT / 8)));
        write_reg(CFG_MU1, t_word'($urandom_range(0, UNIT)));
        write_reg(CFG_MU2, t_word'($urandom_range(0, UNIT)));
        write_reg(CFG_KA, -t_word'($urandom_range(0, 8 * UNIT)));
        write_reg(CFG_UNUSED_IDX, t_word'($urandom));
        cfg_valid <= 1'b0;
        queue_random(135);
        drain();

        // phase 2: extreme settings, sender idles often
        write_reg(CFG_K, WORD_MAX);
        write_reg(CFG_A, WORD_MIN);
        write_reg(CFG_B, WORD_MAX);
        write_reg(CFG_IC, WORD_MIN);
        write_reg(CFG_EPS, WORD_MAX);
        write_reg(CFG_MU1, WORD_MIN);
        write_reg(CFG_MU2, 32'sd0);
        write_reg(CFG_KA, WORD_MAX);
        cfg_valid <= 1'b0;
        idle_pct = 72;
        queue_random(135);
        drain();

        // phase 3: random registers with mu2 at its minimum, back-to-back stream
        write_reg(CFG_K, t_word'($urandom));
        write_reg(CFG_A, t_word'($urandom));
        write_reg(CFG_B, t_word'($urandom));
        write_reg(CFG_IC, t_word'($urandom));
        write_reg(CFG_EPS, t_word'($urandom));
        write_reg(CFG_MU1, t_word'($urandom));
        write_reg(CFG_MU2, WORD_MIN);
        write_reg(CFG_KA, t_word'($urandom));
        cfg_valid <= 1'b0;
        idle_pct = 0;
        queue_random(135);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && rate_queue.size() == 0) begin
            $display("cardiac_reaction_rates regression: pass");
        end else begin
            $display("cardiac_reaction_rates regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("cardiac_reaction_rates regression: fail");
        $finish;
    end

endmodule
